// ----- hw/rtl/wmf_pkg.sv -----
// shared types and constants for the windowed median filter
package wmf_pkg;

    localparam int CNT_W    = 21;
    localparam int MAX_ROWS = 1024;
    localparam int ROW_W    = 10;
    localparam int PADDR_W  = 5;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_WINDOW_HEIGHT = 3'd2,
        REG_WINDOW_WIDTH  = 3'd3,
        REG_ANCHOR_X      = 3'd4,
        REG_ANCHOR_Y      = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PASS,
        ST_READ,
        ST_SETTLE,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  pixel_out;
        logic [9:0]  out_row;
        logic [9:0]  out_col;
        logic        filtered;
        logic        last_of_frame;
    } out_item_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } sort_ctrl_t;

endpackage

// ----- hw/rtl/windowed_median_filter.sv -----
// top level of the windowed median filter
// usage:
//   pixels enter on the s_ channel in raster order, top row first; cmd = 1 is a
//   drain transaction that only lets one pending result out at frame end
//   results leave on the m_ channel in raster order with row, column, a flag
//   telling a median from a border pass-through, and a last-of-frame flag
//   one input transaction is taken at a time: after acceptance the block checks
//   whether the window of the next pending pixel is complete; if not it returns
//   to idle and is ready again; a border pixel takes one history read; a median
//   of n = wh*ww values takes n history reads through the single read port of
//   the history memory (one window pixel per cycle), then a settle step and the
//   shifts of the sort row
//   results sit in an output register, so the next transaction is taken while a
//   result waits; a stalled receiver holds the block only when a new result
//   must be loaded
//   reset restores the default geometry (1024x1024, 3x3 window, anchor 1,1) and
//   clears the frame counters; history memory content is not cleared
//   a write to any defined register starts a new frame and holds s_ready low
//   until the settle counter has run down; history depth must be a power of two
module windowed_median_filter #(
    parameter int MAX_WINDOW    = 5,
    parameter int MAX_LINE      = 1024,
    parameter int HISTORY_DEPTH = 8192
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  wmf_pkg::in_item_t          s_data,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output wmf_pkg::out_item_t         m_data,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wmf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import wmf_pkg::*;

    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int LW   = $clog2(MAX_LINE + 1);   // clamped width value
    localparam int CW   = $clog2(MAX_LINE);       // column counter
    localparam int WW_W = $clog2(MAX_WINDOW + 1); // window size value
    localparam int N    = MAX_WINDOW * MAX_WINDOW;
    localparam int NW   = $clog2(N + 1);

    // configuration registers as written
    logic [10:0] img_w_reg, img_h_reg;
    logic [2:0]  win_h_reg, win_w_reg, anc_x_reg, anc_y_reg;
    logic        cfg_wr, cfg_hit;
    logic [1:0]  settle_reg, settle_next;

    // stage 1: clamped geometry
    logic [LW-1:0]   w_eff_reg, w_eff_next;
    logic [10:0]     h_eff_reg, h_eff_next;
    logic [WW_W-1:0] wh_reg, wh_next, ww_reg, ww_next, ax_reg, ax_next, ay_reg, ay_next;

    // stage 2: products of the geometry
    logic [CNT_W-1:0] total_reg, ayw_reg, aheadw_reg;
    logic [WW_W-1:0]  xoff_reg;
    logic [NW-1:0]    n_reg;

    // frame counters
    logic [CNT_W-1:0] taken_reg, taken_next, given_reg, given_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]    col_reg, col_next;

    state_t state_reg, state_next;

    // window walk
    logic [CNT_W-1:0] row_addr_reg, row_addr_next;
    logic [WW_W-1:0]  k_reg, k_next, l_reg, l_next;
    logic [NW-1:0]    shift_reg, shift_next;
    logic             rd_pend_reg;
    logic             filt_reg, filt_next;

    // output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    // memory and sorter hookup
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    sort_ctrl_t    sctrl;
    logic [7:0]    s_lo, s_hi;

    logic             in_fire, take_pixel, out_free;
    logic             filt_c, res_ready;
    logic [CNT_W-1:0] need_c, base_c;
    logic [8:0]       mid_sum;
    logic [7:0]       res_val;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    // only writes to a defined register open a new frame
    assign cfg_hit = cfg_wr && (paddr[4:2] <= REG_ANCHOR_Y);
    assign s_ready = (state_reg == ST_IDLE) && (settle_reg == 2'd0);
    assign in_fire = s_valid && s_ready;
    assign take_pixel = in_fire && !s_data.cmd && (taken_reg < total_reg);
    assign out_free   = !out_valid_reg || m_ready;
    assign mem_we     = take_pixel;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg <= 11'd1024;
            img_h_reg <= 11'd1024;
            win_h_reg <= 3'd3;
            win_w_reg <= 3'd3;
            anc_x_reg <= 3'd1;
            anc_y_reg <= 3'd1;
        end else if (cfg_wr) begin
            case (reg_idx_t'(paddr[4:2]))
                REG_IMAGE_WIDTH:   img_w_reg <= pwdata[10:0];
                REG_IMAGE_HEIGHT:  img_h_reg <= pwdata[10:0];
                REG_WINDOW_HEIGHT: win_h_reg <= pwdata[2:0];
                REG_WINDOW_WIDTH:  win_w_reg <= pwdata[2:0];
                REG_ANCHOR_X:      anc_x_reg <= pwdata[2:0];
                REG_ANCHOR_Y:      anc_y_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        prdata = '0;
        case (reg_idx_t'(paddr[4:2]))
            REG_IMAGE_WIDTH:   prdata = {21'd0, img_w_reg};
            REG_IMAGE_HEIGHT:  prdata = {21'd0, img_h_reg};
            REG_WINDOW_HEIGHT: prdata = {29'd0, win_h_reg};
            REG_WINDOW_WIDTH:  prdata = {29'd0, win_w_reg};
            REG_ANCHOR_X:      prdata = {29'd0, anc_x_reg};
            REG_ANCHOR_Y:      prdata = {29'd0, anc_y_reg};
            default:           prdata = '0;
        endcase
    end

    // clamp zero and oversized values, keep the anchor inside the window
    always_comb begin
        int wi, hi, whi, wwi, axi, ayi;
        wi  = int'(img_w_reg);
        hi  = int'(img_h_reg);
        whi = int'(win_h_reg);
        wwi = int'(win_w_reg);
        axi = int'(anc_x_reg);
        ayi = int'(anc_y_reg);
        if (wi == 0) wi = 1; else if (wi > MAX_LINE) wi = MAX_LINE;
        if (hi == 0) hi = 1; else if (hi > MAX_ROWS) hi = MAX_ROWS;
        if (whi == 0) whi = 1; else if (whi > MAX_WINDOW) whi = MAX_WINDOW;
        if (wwi == 0) wwi = 1; else if (wwi > MAX_WINDOW) wwi = MAX_WINDOW;
        if (axi >= wwi) axi = wwi - 1;
        if (ayi >= whi) ayi = whi - 1;
        w_eff_next = LW'(wi);
        h_eff_next = 11'(hi);
        wh_next    = WW_W'(whi);
        ww_next    = WW_W'(wwi);
        ax_next    = WW_W'(axi);
        ay_next    = WW_W'(ayi);
    end

    // geometry pipeline: clamped values, then their products
    always_ff @(posedge aclk) begin
        w_eff_reg  <= w_eff_next;
        h_eff_reg  <= h_eff_next;
        wh_reg     <= wh_next;
        ww_reg     <= ww_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        total_reg  <= CNT_W'(w_eff_reg * h_eff_reg);
        ayw_reg    <= CNT_W'(ay_reg * w_eff_reg);
        aheadw_reg <= CNT_W'((wh_reg - ay_reg - WW_W'(1)) * w_eff_reg);
        xoff_reg   <= ww_reg - ax_reg - WW_W'(1);
        n_reg      <= NW'(wh_reg * ww_reg);
    end

    // is the next pending result's window complete
    always_comb begin
        filt_c = (CNT_W'(row_reg) >= CNT_W'(ay_reg))
              && (CNT_W'(row_reg) + CNT_W'(wh_reg) <= CNT_W'(h_eff_reg) + CNT_W'(ay_reg))
              && (CNT_W'(col_reg) >= CNT_W'(ax_reg))
              && (CNT_W'(col_reg) + CNT_W'(ww_reg) <= CNT_W'(w_eff_reg) + CNT_W'(ax_reg));
        need_c = filt_c ? given_reg + aheadw_reg + CNT_W'(xoff_reg) : given_reg;
        base_c = given_reg - ayw_reg - CNT_W'(ax_reg);
        res_ready = (given_reg < taken_reg) && (need_c < taken_reg);
    end

    // median from the shifted sort row, or the raw pixel at the border
    always_comb begin
        mid_sum = {1'b0, s_lo} + {1'b0, s_hi};
        if (!filt_reg) begin
            res_val = mem_rdata;
        end else if (n_reg[0]) begin
            res_val = s_lo;
        end else begin
            res_val = mid_sum[8:1];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!res_ready) begin
                    state_next = ST_IDLE;
                end else if (filt_c) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS: state_next = ST_EMIT;
            ST_READ: begin
                if (l_reg == ww_reg - WW_W'(1) && k_reg == wh_reg - WW_W'(1)) begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: state_next = ST_SHIFT;
            ST_SHIFT: begin
                if (shift_reg == '0) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and counter updates
    always_comb begin
        taken_next     = taken_reg;
        given_next     = given_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        row_addr_next  = row_addr_reg;
        k_next         = k_reg;
        l_next         = l_reg;
        shift_next     = shift_reg;
        filt_next      = filt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        mem_re         = 1'b0;
        mem_raddr      = given_reg[AW-1:0];
        sctrl          = '0;
        sctrl.insert   = rd_pend_reg;
        settle_next    = (settle_reg != 2'd0) ? settle_reg - 2'd1 : 2'd0;

        case (state_reg)
            ST_IDLE: begin
                if (take_pixel) taken_next = taken_reg + CNT_W'(1);
            end
            ST_CHECK: begin
                filt_next     = filt_c;
                row_addr_next = base_c;
                k_next        = '0;
                l_next        = '0;
                sctrl.clear   = 1'b1;
                // border pixel: read it straight away
                if (res_ready && !filt_c) mem_re = 1'b1;
            end
            ST_READ: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(row_addr_reg + CNT_W'(l_reg));
                if (l_reg == ww_reg - WW_W'(1)) begin
                    l_next        = '0;
                    k_next        = k_reg + WW_W'(1);
                    row_addr_next = row_addr_reg + CNT_W'(w_eff_reg);
                end else begin
                    l_next = l_reg + WW_W'(1);
                end
            end
            ST_SETTLE: begin
                // odd count: middle at n/2, even count: pair at n/2-1 and n/2
                shift_next = n_reg[0] ? (n_reg >> 1) : (n_reg >> 1) - NW'(1);
            end
            ST_SHIFT: begin
                if (shift_reg != '0) begin
                    sctrl.shift = 1'b1;
                    shift_next  = shift_reg - NW'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next         = 1'b1;
                    out_next.pixel_out     = res_val;
                    out_next.out_row       = row_reg[9:0];
                    out_next.out_col       = 10'(col_reg);
                    out_next.filtered      = filt_reg;
                    out_next.last_of_frame = (given_reg + CNT_W'(1) == total_reg);
                    if (given_reg + CNT_W'(1) >= total_reg) begin
                        given_next = '0;
                        taken_next = '0;
                        row_next   = '0;
                        col_next   = '0;
                    end else begin
                        given_next = given_reg + CNT_W'(1);
                        if (CNT_W'(col_reg) + CNT_W'(1) == CNT_W'(w_eff_reg)) begin
                            col_next = '0;
                            row_next = row_reg + ROW_W'(1);
                        end else begin
                            col_next = col_reg + CW'(1);
                        end
                    end
                end
            end
            default: ;
        endcase

        // any write to a defined register opens a new frame
        if (cfg_hit) begin
            taken_next  = '0;
            given_next  = '0;
            row_next    = '0;
            col_next    = '0;
            settle_next = 2'd3;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            taken_reg     <= '0;
            given_reg     <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            settle_reg    <= 2'd3;
        end else begin
            state_reg     <= state_next;
            taken_reg     <= taken_next;
            given_reg     <= given_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= mem_re && (state_reg == ST_READ);
            settle_reg    <= settle_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_addr_reg <= row_addr_next;
        k_reg        <= k_next;
        l_reg        <= l_next;
        shift_reg    <= shift_next;
        filt_reg     <= filt_next;
        out_reg      <= out_next;
    end

    wmf_hist_ram #(
        .DEPTH(HISTORY_DEPTH),
        .AW   (AW)
    ) u_hist (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(taken_reg[AW-1:0]),
        .wdata(s_data.pixel_in),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    wmf_sorter #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_sort (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (sctrl),
        .din    (mem_rdata),
        .lo     (s_lo),
        .hi     (s_hi)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
endmodule

// ----- hw/rtl/wmf_hist_ram.sv -----
// pixel history memory, one write port and one registered read port
module wmf_hist_ram #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- hw/rtl/wmf_sorter.sv -----
// window scratch: insertion into a sorted register row, then shift toward the median
module wmf_sorter #(
    parameter int MAX_WINDOW = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  wmf_pkg::sort_ctrl_t ctrl,
    input  logic [7:0]          din,
    output logic [7:0]          lo,
    output logic [7:0]          hi
);
    import wmf_pkg::*;

    localparam int N  = MAX_WINDOW * MAX_WINDOW;
    localparam int NW = $clog2(N + 1);

    logic [7:0]    sv_reg  [N];
    logic [7:0]    sv_next [N];
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [N-1:0]  le;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            le[i] = (i < int'(cnt_reg)) && (sv_reg[i] <= din);
        end
        for (int i = 0; i < N; i++) begin
            sv_next[i] = sv_reg[i];
            if (ctrl.insert) begin
                if (le[i]) begin
                    sv_next[i] = sv_reg[i];
                end else if (i == 0 || le[(i > 0) ? i - 1 : 0]) begin
                    sv_next[i] = din;
                end else begin
                    sv_next[i] = sv_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (ctrl.shift) begin
                sv_next[i] = sv_reg[(i < N - 1) ? i + 1 : i];
            end
        end
        cnt_next = cnt_reg;
        if (ctrl.clear) begin
            cnt_next = '0;
        end else if (ctrl.insert && int'(cnt_reg) < N) begin
            cnt_next = cnt_reg + NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < N; i++) begin
            sv_reg[i] <= sv_next[i];
        end
    end

    assign lo = sv_reg[0];
    assign hi = sv_reg[(N > 1) ? 1 : 0];
endmodule
